// ===== rtl/beat_synced_loop_recorder_assert.svh =====
// Assertion macros for the beat-synced loop recorder.
`ifndef BEAT_SYNCED_LOOP_RECORDER_ASSERT_SVH
`define BEAT_SYNCED_LOOP_RECORDER_ASSERT_SVH

// same-cycle implication
`define BSLR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bslr assertion failed");

// next-cycle implication
`define BSLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bslr assertion failed");

`endif

// ===== rtl/bslr_pkg.sv =====
// Package: shared types and constants of the beat-synced loop recorder.
package bslr_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_COUNT = 2'd1,
      MODE_REC   = 2'd2,
      MODE_PLAY  = 2'd3
   } mode_type;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_START  = 1'b1;

   localparam int PERIOD_W   = 16;
   localparam int BEATS_W    = 6;
   localparam int LENGTH_W   = 23;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_PERIOD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEATS_PER_LOOP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_LENGTH    = 2'd2;

   localparam logic [PERIOD_W-1:0] BEAT_PERIOD_RESET    = 16'd22050;
   localparam logic [BEATS_W-1:0]  BEATS_PER_LOOP_RESET = 6'd16;
   localparam logic [LENGTH_W-1:0] LOOP_LENGTH_RESET    = 23'd352800;

   typedef struct packed {
      mode_type             mode;
      logic [BEATS_W-1:0]   beat_number;
      logic                 beat_pulse;
      logic                 play;
   } item_ctrl_type;

endpackage

// ===== rtl/bslr_req_if.sv =====
// Interface: request channel carrying input samples and start commands.
interface bslr_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, kind, sample_in, input ready);
   modport sink   (input valid, kind, sample_in, output ready);
endinterface

// ===== rtl/bslr_rsp_if.sv =====
// Interface: result channel carrying played samples and loop status.
interface bslr_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                               valid;
   logic                               ready;
   logic signed [SAMPLE_BITS-1:0]      sample_out;
   bslr_pkg::mode_type                 mode;
   logic [bslr_pkg::BEATS_W-1:0]       beat_number;
   logic                               beat_pulse;

   modport source (output valid, sample_out, mode, beat_number, beat_pulse, input ready);
   modport sink   (input valid, sample_out, mode, beat_number, beat_pulse, output ready);
endinterface

// ===== rtl/beat_synced_loop_recorder.sv =====
// Top level: beat-synced loop recorder with single-port sample store and fade pipeline.
// Pipeline: an accepted request moves through the store-read, product, quotient and result registers to rsp.
// Throughput: one request per cycle unless stalled; the store takes at most one write or one read per request.
// Stalls: the whole pipeline holds while the result register is full and not taken.
// Reset: clears counters, pointers, mode and pipeline valids; registers take defaults.
// The store is not cleared; playback does not check that an entry was recorded.
module beat_synced_loop_recorder #(
   parameter int STORE_DEPTH    = 4194304,
   parameter int SAMPLE_BITS    = 16,
   parameter int COUNT_IN_BEATS = 4,
   parameter int FADE_SAMPLES   = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [bslr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bslr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   bslr_req_if.sink                            req_chan,
   bslr_rsp_if.source                          rsp_chan
);

   localparam int PTR_W   = $clog2(STORE_DEPTH);
   localparam int LEN_W   = PTR_W + 1;
   localparam int CMP_W   = (LEN_W > bslr_pkg::LENGTH_W) ? LEN_W : bslr_pkg::LENGTH_W;
   localparam int GAIN_W  = $clog2(FADE_SAMPLES + 1);
   localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
   localparam int MAG_W   = SAMPLE_BITS + GAIN_W - 1;
   localparam int SHIFT   = MAG_W + $clog2(FADE_SAMPLES);
   localparam int RECIP_W = MAG_W + 1;
   localparam int RPROD_W = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(FADE_SAMPLES) - 64'd1) / 64'(FADE_SAMPLES));
   localparam int BW = bslr_pkg::BEATS_W;
   localparam int PW = bslr_pkg::PERIOD_W;

   function automatic logic [LEN_W-1:0] eff_len(input logic [bslr_pkg::LENGTH_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w == '0) begin
         return LEN_W'(1);
      end else if (w > CMP_W'(STORE_DEPTH)) begin
         return LEN_W'(STORE_DEPTH);
      end else begin
         return w[LEN_W-1:0];
      end
   endfunction

   // configuration
   logic [PW-1:0]    period_ff;
   logic [BW-1:0]    beats_ff;
   logic [LEN_W-1:0] len_ff;

   // loop state
   logic [PW-1:0]          counter_ff, counter_in;
   logic [BW-1:0]          index_ff, index_in;
   bslr_pkg::mode_type     mode_ff, mode_in;
   logic [LEN_W-1:0]       wp_ff, wp_in;
   logic [PTR_W-1:0]       rp_ff, rp_in;

   // request stage
   logic                    adv, accept, rec_wr, play, pulse;
   logic [PTR_W-1:0]        wr_addr, rd_addr;
   logic [GAIN_W-1:0]       gain;
   bslr_pkg::item_ctrl_type ctrl0;

   // pipeline
   logic                          v1_ff, v2_ff, v3_ff, out_valid_ff;
   bslr_pkg::item_ctrl_type       c1_ff, c2_ff, c3_ff, out_ctrl_ff;
   logic [GAIN_W-1:0]             g1_ff;
   logic [SAMPLE_BITS-1:0]        mem_q_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic [MAG_W-1:0]              mag;
   logic [RPROD_W-1:0]            rprod;
   logic [SAMPLE_BITS-1:0]        quo_ff;
   logic                          neg_ff;
   logic [SAMPLE_BITS-1:0]        sample_out_ff;

   logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];

   always_comb begin
      logic [PW:0]      next_count;
      logic [BW-1:0]    inc;
      logic [PTR_W-1:0] rp_eff;
      logic [LEN_W-1:0] remain;
      logic [LEN_W-1:0] rp_nxt;
      adv        = !out_valid_ff || rsp_chan.ready;
      accept     = req_chan.valid && adv && !reset;
      next_count = {1'b0, counter_ff} + (PW + 1)'(1);
      inc        = index_ff + BW'(1);
      counter_in = counter_ff;
      index_in   = index_ff;
      mode_in    = mode_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      rec_wr     = 1'b0;
      play       = 1'b0;
      pulse      = 1'b0;
      gain       = '0;
      wr_addr    = wp_ff[PTR_W-1:0];
      rd_addr    = rp_ff;
      rp_eff     = rp_ff;
      remain     = '0;
      rp_nxt     = '0;
      if (accept) begin
         if (req_chan.kind == bslr_pkg::KIND_START) begin
            index_in   = BW'(COUNT_IN_BEATS);
            counter_in = '0;
            mode_in    = bslr_pkg::MODE_COUNT;
         end else begin
            if (next_count > {1'b0, period_ff}) begin
               pulse      = 1'b1;
               counter_in = '0;
               if (mode_ff == bslr_pkg::MODE_COUNT) begin
                  if (index_ff == '0) begin
                     wp_in   = '0;
                     mode_in = bslr_pkg::MODE_REC;
                  end else begin
                     index_in = index_ff - BW'(1);
                  end
               end else if (inc == beats_ff) begin
                  index_in = '0;
                  if (mode_ff == bslr_pkg::MODE_REC) begin
                     rp_in   = '0;
                     mode_in = bslr_pkg::MODE_PLAY;
                  end
               end else begin
                  index_in = inc;
               end
            end else begin
               counter_in = next_count[PW-1:0];
            end
            if (mode_in == bslr_pkg::MODE_REC) begin
               wr_addr = wp_in[PTR_W-1:0];
               if (wp_in < len_ff) begin
                  rec_wr = 1'b1;
                  wp_in  = wp_in + LEN_W'(1);
               end
            end else if (mode_in == bslr_pkg::MODE_PLAY) begin
               play   = 1'b1;
               rp_eff = ({1'b0, rp_in} >= len_ff) ? '0 : rp_in;
               gain   = GAIN_W'(FADE_SAMPLES);
               if (rp_eff < PTR_W'(FADE_SAMPLES)) begin
                  gain = rp_eff[GAIN_W-1:0];
               end
               remain = len_ff - {1'b0, rp_eff};
               if (remain < LEN_W'(FADE_SAMPLES)) begin
                  gain = remain[GAIN_W-1:0];
               end
               rd_addr = rp_eff;
               rp_nxt  = {1'b0, rp_eff} + LEN_W'(1);
               rp_in   = (rp_nxt >= len_ff) ? '0 : rp_nxt[PTR_W-1:0];
            end
         end
      end
      ctrl0.mode        = mode_in;
      ctrl0.beat_number = index_in;
      ctrl0.beat_pulse  = pulse;
      ctrl0.play        = play;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= bslr_pkg::BEAT_PERIOD_RESET;
         beats_ff  <= bslr_pkg::BEATS_PER_LOOP_RESET;
         len_ff    <= eff_len(bslr_pkg::LOOP_LENGTH_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            bslr_pkg::CSR_BEAT_PERIOD:    period_ff <= csr_wdata[PW-1:0];
            bslr_pkg::CSR_BEATS_PER_LOOP: beats_ff  <= csr_wdata[BW-1:0];
            bslr_pkg::CSR_LOOP_LENGTH:    len_ff    <= eff_len(csr_wdata[bslr_pkg::LENGTH_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         index_ff   <= '0;
         mode_ff    <= bslr_pkg::MODE_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
      end else if (accept) begin
         counter_ff <= counter_in;
         index_ff   <= index_in;
         mode_ff    <= mode_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_wr) begin
         store_mem[wr_addr] <= req_chan.sample_in;
      end else if (play) begin
         mem_q_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_comb begin
      prod_in = PROD_W'($signed(mem_q_ff)) * PROD_W'($signed({1'b0, g1_ff}));
      mag     = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
      rprod   = RPROD_W'(mag) * RPROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff       <= ctrl0;
         g1_ff       <= gain;
         c2_ff       <= c1_ff;
         prod_ff     <= prod_in;
         c3_ff       <= c2_ff;
         quo_ff      <= rprod[SHIFT +: SAMPLE_BITS];
         neg_ff      <= prod_ff[PROD_W-1];
         out_ctrl_ff <= c3_ff;
         if (!c3_ff.play) begin
            sample_out_ff <= '0;
         end else if (neg_ff) begin
            sample_out_ff <= -quo_ff;
         end else begin
            sample_out_ff <= quo_ff;
         end
      end
   end

   assign req_chan.ready       = adv && !reset;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.sample_out  = $signed(sample_out_ff);
   assign rsp_chan.mode        = out_ctrl_ff.mode;
   assign rsp_chan.beat_number = out_ctrl_ff.beat_number;
   assign rsp_chan.beat_pulse  = out_ctrl_ff.beat_pulse;

`include "beat_synced_loop_recorder_assert.svh"

   `BSLR_ASSERT_IMPLY(a_quiet_unless_playing, clock, reset, rsp_chan.valid && rsp_chan.sample_out != '0, rsp_chan.mode == bslr_pkg::MODE_PLAY)
   `BSLR_ASSERT_NEXT(a_start_arms_count_in, clock, reset, accept && req_chan.kind == bslr_pkg::KIND_START, mode_ff == bslr_pkg::MODE_COUNT && counter_ff == '0)
   `BSLR_ASSERT_IMPLY(a_gain_bounded, clock, reset, v1_ff, g1_ff <= GAIN_W'(FADE_SAMPLES) && (c1_ff.play || g1_ff == '0))

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the beat-synced loop recorder: directed and random requests.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH    = 4194304;
   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_IN_BEATS = 4;
   localparam int FADE_SAMPLES   = 10;
   localparam int LATENCY        = 4;
   localparam int STALL_LIMIT    = 2000;
   localparam int PERIOD_W       = bslr_pkg::PERIOD_W;
   localparam int BEATS_W        = bslr_pkg::BEATS_W;
   localparam int LENGTH_W       = bslr_pkg::LENGTH_W;
   localparam int CSR_IDX_W      = bslr_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W     = bslr_pkg::CSR_DATA_W;

   typedef struct packed {
      logic                   kind;
      logic [SAMPLE_BITS-1:0] sample_in;
      logic                   hold;
   } request_item_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_out;
      bslr_pkg::mode_type     mode;
      logic [BEATS_W-1:0]     beat_number;
      logic                   beat_pulse;
   } loop_result_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bslr_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   bslr_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();

   beat_synced_loop_recorder #(
      .STORE_DEPTH    (STORE_DEPTH),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COUNT_IN_BEATS (COUNT_IN_BEATS),
      .FADE_SAMPLES   (FADE_SAMPLES)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

   // predictor state and register copies
   logic [PERIOD_W-1:0] cfg_period = bslr_pkg::BEAT_PERIOD_RESET;
   logic [BEATS_W-1:0]  cfg_beats  = bslr_pkg::BEATS_PER_LOOP_RESET;
   logic [LENGTH_W-1:0] cfg_length = bslr_pkg::LOOP_LENGTH_RESET;
   int unsigned         beat_count = 0;
   logic [BEATS_W-1:0]  beat_idx   = '0;
   bslr_pkg::mode_type  loop_mode  = bslr_pkg::MODE_IDLE;
   int unsigned         wr_ptr     = 0;
   int unsigned         rd_ptr     = 0;
   logic signed [SAMPLE_BITS-1:0] tape [int unsigned];

   request_item_type pending_requests[$];
   loop_result_type  expected_outputs[$];

   int queued_count  = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int mismatches    = 0;
   int src_idle_pct  = 0;
   int snk_stall_pct = 0;
   int idle_cycles   = 0;
   int stale_wraps   = 0;
   int beats_seen    = 0;
   int settings_count = 1;
   int mode_results[4] = '{0, 0, 0, 0};

   int unsigned cur_period;
   int unsigned cur_beats;
   int unsigned cur_len;

   function automatic int unsigned loop_span(int unsigned len);
      if (len > STORE_DEPTH) return STORE_DEPTH;
      if (len == 0) return 1;
      return len;
   endfunction

   function automatic loop_result_type predict_loop_output(logic kind,
                                                           logic [SAMPLE_BITS-1:0] value);
      loop_result_type r;
      int unsigned     span;
      int              gain;
      r = '0;
      if (kind == bslr_pkg::KIND_START) begin
         beat_idx   = BEATS_W'(COUNT_IN_BEATS);
         beat_count = 0;
         loop_mode  = bslr_pkg::MODE_COUNT;
      end else begin
         span = loop_span(cfg_length);
         if (beat_count + 1 > cfg_period) begin
            r.beat_pulse = 1'b1;
            beat_count = 0;
            if (loop_mode == bslr_pkg::MODE_COUNT) begin
               if (beat_idx == 0) begin
                  wr_ptr    = 0;
                  loop_mode = bslr_pkg::MODE_REC;
               end else begin
                  beat_idx = beat_idx - 1'b1;
               end
            end else begin
               beat_idx = beat_idx + 1'b1;
               if (beat_idx == cfg_beats) begin
                  beat_idx = '0;
                  if (loop_mode == bslr_pkg::MODE_REC) begin
                     rd_ptr    = 0;
                     loop_mode = bslr_pkg::MODE_PLAY;
                  end
               end
            end
         end else begin
            beat_count++;
         end
         if (loop_mode == bslr_pkg::MODE_REC) begin
            if (wr_ptr < span) begin
               tape[wr_ptr] = value;
               wr_ptr++;
            end
         end else if (loop_mode == bslr_pkg::MODE_PLAY) begin
            if (rd_ptr >= span) begin
               rd_ptr = 0;
               stale_wraps++;
            end
            gain = FADE_SAMPLES;
            if (rd_ptr < FADE_SAMPLES) gain = int'(rd_ptr);
            if (span - rd_ptr < FADE_SAMPLES) gain = int'(span - rd_ptr);
            r.sample_out = SAMPLE_BITS'((tape[rd_ptr] * gain) / FADE_SAMPLES);
            rd_ptr++;
            if (rd_ptr >= span) rd_ptr = 0;
         end
      end
      r.mode        = loop_mode;
      r.beat_number = beat_idx;
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic void queue_request(logic kind, logic [SAMPLE_BITS-1:0] value,
                                         logic hold);
      request_item_type item;
      item.kind      = kind;
      item.sample_in = value;
      item.hold      = hold;
      pending_requests = {pending_requests, item};
      queued_count++;
   endfunction

   // start, full count-in and recording, then some playback; rare stray starts
   function automatic void queue_take(int unsigned playback, logic hold);
      int unsigned body;
      body = (COUNT_IN_BEATS + 1 + cur_beats) * (cur_period + 1) + playback;
      queue_request(bslr_pkg::KIND_START, SAMPLE_BITS'($urandom), hold);
      for (int unsigned i = 0; i < body; i++) begin
         if ($urandom_range(0, 149) == 0) begin
            queue_request(bslr_pkg::KIND_START, random_sample(), 1'b0);
         end else begin
            queue_request(bslr_pkg::KIND_SAMPLE, random_sample(), 1'b0);
         end
      end
   endfunction

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      case (index)
         bslr_pkg::CSR_BEAT_PERIOD:    cfg_period = value[PERIOD_W-1:0];
         bslr_pkg::CSR_BEATS_PER_LOOP: cfg_beats  = value[BEATS_W-1:0];
         bslr_pkg::CSR_LOOP_LENGTH:    cfg_length = value[LENGTH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic close_register_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_count++;
   endtask

   task automatic drain_outputs();
      while (accepted_count != queued_count || checked_count != queued_count) begin
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : request_driver
      request_item_type item;
      loop_result_type  predicted;
      logic             took;
      logic             busy;
      took = req_chan.valid && req_chan.ready;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (took) begin
            predicted = predict_loop_output(req_chan.kind, req_chan.sample_in);
            expected_outputs = {expected_outputs, predicted};
            accepted_count <= accepted_count + 1;
         end
         busy = (accepted_count + int'(took)) != checked_count;
         if (!req_chan.valid || took) begin
            if (pending_requests.size() != 0 && !(pending_requests[0].hold && busy)
                  && $urandom_range(0, 99) >= src_idle_pct) begin
               item = pending_requests.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.kind      <= item.kind;
               req_chan.sample_in <= item.sample_in;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      loop_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked_count <= checked_count + 1;
            mode_results[int'(rsp_chan.mode)]++;
            if (rsp_chan.beat_pulse) beats_seen++;
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected result, sample_out %0d mode %0d beat %0d pulse %0d",
                        $time, rsp_chan.sample_out, rsp_chan.mode, rsp_chan.beat_number,
                        rsp_chan.beat_pulse);
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_chan.sample_out !== want.sample_out) begin
                  $display("%0t: sample_out expected %0d got %0d", $time,
                           $signed(want.sample_out), rsp_chan.sample_out);
                  mismatches++;
               end
               if (rsp_chan.mode !== want.mode) begin
                  $display("%0t: mode expected %0d got %0d", $time, want.mode, rsp_chan.mode);
                  mismatches++;
               end
               if (rsp_chan.beat_number !== want.beat_number) begin
                  $display("%0t: beat_number expected %0d got %0d", $time,
                           want.beat_number, rsp_chan.beat_number);
                  mismatches++;
               end
               if (rsp_chan.beat_pulse !== want.beat_pulse) begin
                  $display("%0t: beat_pulse expected %0d got %0d", $time,
                           want.beat_pulse, rsp_chan.beat_pulse);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          phase_base;
      int unsigned span_now;
      logic        first_take;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.kind      = bslr_pkg::KIND_SAMPLE;
      req_chan.sample_in = '0;
      rsp_chan.ready     = 1'b0;
      cur_period = bslr_pkg::BEAT_PERIOD_RESET;
      cur_beats  = bslr_pkg::BEATS_PER_LOOP_RESET;
      cur_len    = bslr_pkg::LOOP_LENGTH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default registers: idle output, then a count-in that never reaches a beat
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h7FFF, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h8000, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h0000, 1'b0);
      queue_request(bslr_pkg::KIND_START, 16'hFFFF, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'hFFFF, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h5A5A, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'hA5A5, 1'b0);
      drain_outputs();

      // zero period and zero length: every sample beats, one-entry loop
      write_register(bslr_pkg::CSR_BEAT_PERIOD, '0);
      write_register(bslr_pkg::CSR_BEATS_PER_LOOP, CSR_DATA_W'(1));
      write_register(bslr_pkg::CSR_LOOP_LENGTH, '0);
      close_register_writes();
      queue_request(bslr_pkg::KIND_START, 16'h0000, 1'b0);
      repeat (4) queue_request(bslr_pkg::KIND_SAMPLE, random_sample(), 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h8000, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h7FFF, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'h0001, 1'b0);
      queue_request(bslr_pkg::KIND_SAMPLE, 16'hFFFF, 1'b0);
      drain_outputs();

      // largest period and loop length, with 60 beats per loop
      write_register(bslr_pkg::CSR_BEAT_PERIOD, CSR_DATA_W'(16'hFFFF));
      write_register(bslr_pkg::CSR_BEATS_PER_LOOP, CSR_DATA_W'(60));
      write_register(bslr_pkg::CSR_LOOP_LENGTH, CSR_DATA_W'(STORE_DEPTH));
      close_register_writes();
      queue_request(bslr_pkg::KIND_START, 16'h8000, 1'b0);
      repeat (3) queue_request(bslr_pkg::KIND_SAMPLE, random_sample(), 1'b0);
      drain_outputs();
      cur_len = STORE_DEPTH;

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
            default: begin src_idle_pct = 30; snk_stall_pct = 30; end
         endcase
         phase_base = queued_count;
         span_now   = loop_span(cur_len);
         if (ph % 3 == 2 && span_now > 1) begin
            // shorten the loop under a running playback
            cur_len = $urandom_range(0, span_now - 1);
            write_register(bslr_pkg::CSR_LOOP_LENGTH, CSR_DATA_W'(cur_len));
            close_register_writes();
            repeat ($urandom_range(3, 12)) begin
               queue_request(bslr_pkg::KIND_SAMPLE, random_sample(), 1'b0);
            end
         end else begin
            cur_period = $urandom_range(0, 5);
            cur_beats  = $urandom_range(1, 6);
            cur_len    = ($urandom_range(0, 7) == 0) ? 0 :
                         $urandom_range(1, cur_beats * cur_period + 1);
            write_register(bslr_pkg::CSR_BEAT_PERIOD, CSR_DATA_W'(cur_period));
            write_register(bslr_pkg::CSR_BEATS_PER_LOOP, CSR_DATA_W'(cur_beats));
            write_register(bslr_pkg::CSR_LOOP_LENGTH, CSR_DATA_W'(cur_len));
            close_register_writes();
         end
         first_take = 1'b1;
         while (queued_count - phase_base < 40) begin
            queue_take($urandom_range(1, 2 * loop_span(cur_len) + 12), !first_take);
            first_take = 1'b0;
         end
         drain_outputs();
      end

      src_idle_pct  = 0;
      snk_stall_pct = 0;
      repeat (4 * LATENCY) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_outputs.size());
         mismatches++;
      end
      $display("Checked %0d results over %0d register settings: idle %0d, count-in %0d, ",
               checked_count, settings_count, mode_results[0], mode_results[1]);
      $display("recording %0d, playback %0d; %0d beats, %0d stale read pointer wraps.",
               mode_results[2], mode_results[3], beats_seen, stale_wraps);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bslr_pkg.sv
rtl/bslr_req_if.sv
rtl/bslr_rsp_if.sv
rtl/beat_synced_loop_recorder.sv
sim/testbench.sv
